>>> src/vlmr_pkg.sv
// Shared types, widths, status codes and defaults for the variable-length message ring.
`default_nettype none
package vlmr_pkg;

    localparam int CAP_W = 11;
    localparam int LEN_W = 10;
    localparam int CNT_W = 10;
    localparam int HIDX_W = 2;

    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int LENGTH_MAX_DEF = 64;
    localparam int HEADER_BYTES_DEF = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] declared_length;
        logic             last_byte;
        logic [LEN_W-1:0] dest_size;
    } cmd_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       data_out;
        logic [LEN_W-1:0] message_length;
        logic             last_result;
        logic [8:0]       messages_stored;
        logic [CAP_W-1:0] space_left;
        logic [LEN_W-1:0] next_length;
    } result_t;

    typedef struct packed {
        cmd_t cmd;
        logic len_bad;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_out_t;

endpackage
`default_nettype wire

>>> src/vlmr_front.sv
// Front end: accepts commands, checks send lengths, and queues them for the back end.
`default_nettype none
module vlmr_front
    import vlmr_pkg::*;
#(
    parameter int LENGTH_MAX   = LENGTH_MAX_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire cmd_t             cmd,
    input  wire logic [CAP_W-1:0] cap,
    input  wire logic             pop,
    output logic                  busy,
    output q_out_t                q
);

    q_item_t    q_mem_reg [2];
    logic       wr_idx_reg;
    logic       rd_idx_reg;
    logic [1:0] count_reg;
    logic       push;
    q_item_t    item;

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy;

    // a send whose length can never fit is marked here
    always_comb
    begin
        item.cmd = cmd;
        item.len_bad = (cmd.declared_length == '0)
            || (cmd.declared_length > LEN_W'(LENGTH_MAX))
            || ((CAP_W'(cmd.declared_length) + CAP_W'(HEADER_BYTES)) > cap);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_idx_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_idx_reg <= ~wr_idx_reg;
            end
            if (pop)
            begin
                rd_idx_reg <= ~rd_idx_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign q.valid = (count_reg != 2'd0);
    assign q.item = q_mem_reg[rd_idx_reg];

endmodule
`default_nettype wire

>>> src/vlmr_back.sv
// Back end: ring memory, pointers and counts; writes sends, streams receives.
`default_nettype none
module vlmr_back
    import vlmr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int LENGTH_MAX   = LENGTH_MAX_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic [CAP_W-1:0] cap,
    input  wire q_out_t           q,
    output logic                  pop,
    output logic                  result_valid,
    output result_t               result
);

    localparam int PW = $clog2(BUFFER_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_SEND_HDR, S_SEND_BODY, S_REC_HDR, S_REC_STREAM
    } state_t;

    logic [7:0] ring_mem [BUFFER_BYTES];
    logic [7:0] rdata_reg;
    logic       we;
    logic [PW-1:0] waddr;
    logic [PW-1:0] raddr;
    logic [7:0] wdata;

    state_t state_reg, state_next;
    logic [CAP_W-1:0] rp_reg, rp_next;
    logic [CAP_W-1:0] cwp_reg, cwp_next;
    logic [CAP_W-1:0] pwp_reg, pwp_next;
    logic [CAP_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] mcount_reg, mcount_next;
    logic             in_prog_reg, in_prog_next;
    logic [2:0]       outcome_reg, outcome_next;
    logic [LEN_W-1:0] declared_reg, declared_next;
    logic [LEN_W-1:0] bcount_reg, bcount_next;
    logic [LEN_W-1:0] head_len_reg, head_len_next;
    cmd_t             cur_reg, cur_next;
    logic [HIDX_W-1:0] hdr_idx_reg, hdr_idx_next;
    logic [HIDX_W-1:0] hdr_got_reg, hdr_got_next;
    logic [CAP_W-1:0] hp_reg, hp_next;
    logic [CAP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [LEN_W-1:0] slen_reg, slen_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             rd_last_reg, rd_last_next;
    logic             res_valid_reg, res_valid_next;
    result_t          res_reg, res_next;

    // body step inputs
    logic             b_do;
    cmd_t             b_cmd;
    logic [2:0]       b_out;
    logic [LEN_W-1:0] b_decl;
    logic [LEN_W-1:0] b_cnt;
    logic [LEN_W-1:0] cnt1;
    logic [CAP_W-1:0] pwp1;
    logic [2:0]       st;
    logic [2:0]       first_out;
    logic [LEN_W-1:0] l_head;

    // emission
    logic             emit;
    logic [2:0]       e_st;
    logic [7:0]       e_data;
    logic [LEN_W-1:0] e_len;
    logic             e_last;

    function automatic logic [CAP_W-1:0] ring_nxt(input logic [CAP_W-1:0] p,
                                                  input logic [CAP_W-1:0] c);
        logic [CAP_W:0] s;
        s = {1'b0, p} + 1'b1;
        ring_nxt = (s >= {1'b0, c}) ? '0 : s[CAP_W-1:0];
    endfunction

    function automatic logic [CAP_W-1:0] ring_add(input logic [CAP_W-1:0] p,
                                                  input logic [CAP_W-1:0] a,
                                                  input logic [CAP_W-1:0] c);
        logic [CAP_W:0] s;
        logic [CAP_W:0] t;
        s = {1'b0, p} + {1'b0, a};
        t = s - {1'b0, c};
        ring_add = (s >= {1'b0, c}) ? t[CAP_W-1:0] : s[CAP_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] hdr_mask(input logic [LEN_W-1:0] d);
        hdr_mask = (HEADER_BYTES == 1) ? {2'b00, d[7:0]} : d;
    endfunction

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_mem[waddr] <= wdata;
        end
        rdata_reg <= ring_mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        rp_next = rp_reg;
        cwp_next = cwp_reg;
        pwp_next = pwp_reg;
        used_next = used_reg;
        mcount_next = mcount_reg;
        in_prog_next = in_prog_reg;
        outcome_next = outcome_reg;
        declared_next = declared_reg;
        bcount_next = bcount_reg;
        head_len_next = head_len_reg;
        cur_next = cur_reg;
        hdr_idx_next = hdr_idx_reg;
        hdr_got_next = hdr_got_reg;
        hp_next = hp_reg;
        rd_ptr_next = rd_ptr_reg;
        left_next = left_reg;
        slen_next = slen_reg;
        rd_pend_next = 1'b0;
        rd_last_next = 1'b0;
        pop = 1'b0;
        we = 1'b0;
        waddr = PW'(pwp_reg);
        wdata = 8'd0;
        raddr = PW'(rd_ptr_reg);
        b_do = 1'b0;
        b_cmd = cur_reg;
        b_out = outcome_reg;
        b_decl = declared_reg;
        b_cnt = bcount_reg;
        emit = 1'b0;
        e_st = ST_OK;
        e_data = 8'd0;
        e_len = '0;
        e_last = 1'b1;
        l_head = head_len_reg;
        first_out = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q.valid)
                begin
                    pop = 1'b1;
                    if (q.item.cmd.opcode == OP_SEND)
                    begin
                        b_cmd = q.item.cmd;
                        if (!in_prog_reg)
                        begin
                            if (q.item.len_bad)
                            begin
                                first_out = ST_INVALID;
                            end
                            else if ((cap - used_reg) <
                                     (CAP_W'(q.item.cmd.declared_length)
                                      + CAP_W'(HEADER_BYTES)))
                            begin
                                first_out = ST_FULL;
                            end
                            in_prog_next = 1'b1;
                            declared_next = q.item.cmd.declared_length;
                            bcount_next = '0;
                            outcome_next = first_out;
                            if (first_out == ST_OK)
                            begin
                                pwp_next = cwp_reg;
                                cur_next = q.item.cmd;
                                hdr_idx_next = '0;
                                state_next = S_SEND_HDR;
                            end
                            else
                            begin
                                b_do = 1'b1;
                                b_out = first_out;
                                b_decl = q.item.cmd.declared_length;
                                b_cnt = '0;
                            end
                        end
                        else
                        begin
                            b_do = 1'b1;
                        end
                    end
                    else if (mcount_reg == '0)
                    begin
                        emit = 1'b1;
                        e_st = ST_EMPTY;
                    end
                    else if ((l_head > q.item.cmd.dest_size)
                             || (l_head > LEN_W'(LENGTH_MAX)) || (l_head == '0))
                    begin
                        emit = 1'b1;
                        e_st = ST_INVALID;
                        e_len = l_head;
                    end
                    else
                    begin
                        rd_ptr_next = ring_add(rp_reg, CAP_W'(HEADER_BYTES), cap);
                        rp_next = ring_add(rp_reg,
                                           CAP_W'(l_head) + CAP_W'(HEADER_BYTES), cap);
                        hp_next = ring_add(rp_reg,
                                           CAP_W'(l_head) + CAP_W'(HEADER_BYTES), cap);
                        used_next = used_reg - CAP_W'(l_head) - CAP_W'(HEADER_BYTES);
                        mcount_next = mcount_reg - 1'b1;
                        left_next = l_head;
                        slen_next = l_head;
                        head_len_next = '0;
                        hdr_idx_next = '0;
                        hdr_got_next = '0;
                        state_next = (mcount_reg == CNT_W'(1)) ? S_REC_STREAM : S_REC_HDR;
                    end
                end
            end
            S_SEND_HDR:
            begin
                we = 1'b1;
                wdata = (hdr_idx_reg == '0) ? declared_reg[7:0]
                                            : {6'd0, declared_reg[9:8]};
                pwp_next = ring_nxt(pwp_reg, cap);
                hdr_idx_next = hdr_idx_reg + 1'b1;
                if (hdr_idx_reg == HIDX_W'(HEADER_BYTES - 1))
                begin
                    state_next = S_SEND_BODY;
                end
            end
            S_SEND_BODY:
            begin
                b_do = 1'b1;
                state_next = S_IDLE;
            end
            S_REC_HDR:
            begin
                if (hdr_idx_reg != HIDX_W'(HEADER_BYTES))
                begin
                    raddr = PW'(hp_reg);
                    hp_next = ring_nxt(hp_reg, cap);
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    if (hdr_got_reg == '0)
                    begin
                        head_len_next[7:0] = rdata_reg;
                    end
                    else
                    begin
                        head_len_next[9:8] = rdata_reg[1:0];
                    end
                    hdr_got_next = hdr_got_reg + 1'b1;
                    if (hdr_got_reg == HIDX_W'(HEADER_BYTES - 1))
                    begin
                        state_next = S_REC_STREAM;
                    end
                end
            end
            S_REC_STREAM:
            begin
                if (left_reg != '0)
                begin
                    raddr = PW'(rd_ptr_reg);
                    rd_ptr_next = ring_nxt(rd_ptr_reg, cap);
                    left_next = left_reg - 1'b1;
                    rd_pend_next = 1'b1;
                    rd_last_next = (left_reg == LEN_W'(1));
                end
                if (rd_pend_reg)
                begin
                    emit = 1'b1;
                    e_st = ST_OK;
                    e_data = rdata_reg;
                    e_len = slen_reg;
                    e_last = rd_last_reg;
                    if (rd_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // one send byte: count, store within the declared length, close on the last byte
        cnt1 = (b_cnt == LEN_W'(1023)) ? b_cnt : b_cnt + 1'b1;
        pwp1 = pwp_reg;
        st = b_out;
        if (b_do)
        begin
            bcount_next = cnt1;
            if ((b_out == ST_OK) && (cnt1 <= b_decl))
            begin
                we = 1'b1;
                waddr = PW'(pwp_reg);
                wdata = b_cmd.data_byte;
                pwp1 = ring_nxt(pwp_reg, cap);
            end
            pwp_next = pwp1;
            if (b_cmd.last_byte)
            begin
                if ((b_out == ST_OK) && (cnt1 != b_decl))
                begin
                    st = ST_MISMATCH;
                end
                if (st == ST_OK)
                begin
                    cwp_next = pwp1;
                    used_next = used_reg + CAP_W'(b_decl) + CAP_W'(HEADER_BYTES);
                    mcount_next = mcount_reg + 1'b1;
                    if (mcount_reg == '0)
                    begin
                        head_len_next = hdr_mask(b_decl);
                    end
                end
                else
                begin
                    pwp_next = cwp_reg;
                end
                emit = 1'b1;
                e_st = st;
                e_len = b_decl;
                in_prog_next = 1'b0;
                outcome_next = ST_OK;
                bcount_next = '0;
            end
        end

        res_valid_next = emit;
        res_next = res_reg;
        if (emit)
        begin
            res_next.status = e_st;
            res_next.data_out = e_data;
            res_next.message_length = e_len;
            res_next.last_result = e_last;
            res_next.messages_stored = mcount_next[8:0];
            res_next.space_left = cap - used_next;
            res_next.next_length = (mcount_next != '0) ? head_len_next : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rp_reg <= '0;
            cwp_reg <= '0;
            pwp_reg <= '0;
            used_reg <= '0;
            mcount_reg <= '0;
            in_prog_reg <= 1'b0;
            outcome_reg <= ST_OK;
            declared_reg <= '0;
            bcount_reg <= '0;
            head_len_reg <= '0;
            hdr_idx_reg <= '0;
            hdr_got_reg <= '0;
            hp_reg <= '0;
            rd_ptr_reg <= '0;
            left_reg <= '0;
            slen_reg <= '0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            // capacity change empties the ring
            state_reg <= S_IDLE;
            rp_reg <= '0;
            cwp_reg <= '0;
            pwp_reg <= '0;
            used_reg <= '0;
            mcount_reg <= '0;
            in_prog_reg <= 1'b0;
            outcome_reg <= ST_OK;
            declared_reg <= '0;
            bcount_reg <= '0;
            head_len_reg <= '0;
            hdr_idx_reg <= '0;
            hdr_got_reg <= '0;
            hp_reg <= '0;
            rd_ptr_reg <= '0;
            left_reg <= '0;
            slen_reg <= '0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg <= rp_next;
            cwp_reg <= cwp_next;
            pwp_reg <= pwp_next;
            used_reg <= used_next;
            mcount_reg <= mcount_next;
            in_prog_reg <= in_prog_next;
            outcome_reg <= outcome_next;
            declared_reg <= declared_next;
            bcount_reg <= bcount_next;
            head_len_reg <= head_len_next;
            hdr_idx_reg <= hdr_idx_next;
            hdr_got_reg <= hdr_got_next;
            hp_reg <= hp_next;
            rd_ptr_reg <= rd_ptr_next;
            left_reg <= left_next;
            slen_reg <= slen_next;
            rd_pend_reg <= rd_pend_next;
            rd_last_reg <= rd_last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

>>> src/variable_length_message_ring_top.sv
// Top level of the variable-length message ring: capacity register, front end, back end.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------
//  command   | start / busy               | cmd (cmd_t)
//  result    | result_valid strobe        | result (result_t)
//  config    | cfg_valid / cfg_ready      | cfg_data (capacity)
//
// The back end writes the length header ahead of the first byte of an accepted send.
// A receive that leaves another message behind fetches that message's header from the
// single-read-port ring memory before the payload streams out; a receive that empties
// the ring streams its payload directly.
// Busy rises only when both entries of the two-entry command queue are held.
// Reset empties the ring with no clearing pass; results cannot be stalled.
`default_nettype none
module variable_length_message_ring_top
    import vlmr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int LENGTH_MAX   = LENGTH_MAX_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire cmd_t             cmd,
    output logic                  result_valid,
    output result_t               result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data
);

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_eff;
    logic             cfg_wr;
    logic             pop;
    q_out_t           q;

    assign cfg_ready = 1'b1;
    assign cfg_wr = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            cap_reg <= cfg_data;
        end
    end

    // clamp to the physical ring size
    assign cap_eff = (32'(cap_reg) > BUFFER_BYTES) ? CAP_W'(BUFFER_BYTES) : cap_reg;

    vlmr_front #(
        .LENGTH_MAX   (LENGTH_MAX),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .cap   (cap_eff),
        .pop   (pop),
        .busy  (busy),
        .q     (q)
    );

    vlmr_back #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .LENGTH_MAX   (LENGTH_MAX),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (cfg_wr),
        .cap          (cap_eff),
        .q            (q),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire
